FILE: src/iwt_pkg.sv
// integer_to_word_tokens shared definitions: word codes, divider constants,
// microcode control word, step labels and datapath status
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package iwt_pkg;

    localparam int STEP_W = 5;

    localparam logic [4:0] W_CODE_ZERO       = 5'd0;
    localparam logic [4:0] W_CODE_TENS_BASE  = 5'd18;
    localparam logic [4:0] W_CODE_HUNDRED    = 5'd28;
    localparam logic [4:0] W_CODE_SCALE_BASE = 5'd28;

    // floor(v / 1000) = (v * DIV_RECIP) >> DIV_SHIFT, exact for v < 2^31
    localparam logic [31:0] DIV_RECIP  = 32'd2199023256;
    localparam int          DIV_SHIFT  = 41;
    localparam logic [9:0]  GRP_BASE   = 10'd1000;
    // floor(g / 100) for g < 1000, floor(r / 10) for r < 100
    localparam logic [15:0] HUND_RECIP = 16'd41;
    localparam int          HUND_SHIFT = 12;
    localparam logic [9:0]  HUND_BASE  = 10'd100;
    localparam logic [14:0] TENS_RECIP = 15'd205;
    localparam int          TENS_SHIFT = 11;
    localparam logic [6:0]  TENS_BASE  = 7'd10;
    localparam logic [6:0]  TEEN_LIMIT = 7'd20;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_WAIT,
        OP_DIV_MUL,
        OP_DIV_REM,
        OP_LD_HUND,
        OP_LD_REST,
        OP_LD_TENS,
        OP_DEC_GI,
        OP_EMIT,
        OP_FLUSH
    } t_op;

    typedef enum logic [2:0] {
        W_ZERO,
        W_HUND,
        W_HUNDRED,
        W_REST,
        W_TENS,
        W_ONES,
        W_SCALE
    } t_wsel;

    typedef enum logic [3:0] {
        C_NEVER,
        C_ALWAYS,
        C_VAL_ZERO,
        C_GI_NOT2,
        C_GRP_ZERO,
        C_HUND_ZERO,
        C_REST_ZERO,
        C_REST_GE20,
        C_ONES_ZERO,
        C_GI_ZERO
    } t_cond;

    typedef struct packed {
        t_op               op;
        t_wsel             wsel;
        t_cond             cond;
        logic [STEP_W-1:0] target;
    } t_uop;

    typedef struct packed {
        logic val_zero;
        logic gi_two;
        logic gi_zero;
        logic grp_zero;
        logic hund_zero;
        logic rest_zero;
        logic rest_ge20;
        logic ones_zero;
    } t_status;

    localparam logic [STEP_W-1:0] S_IDLE   = 5'd0;
    localparam logic [STEP_W-1:0] S_ZCHK   = 5'd1;
    localparam logic [STEP_W-1:0] S_DMUL   = 5'd2;
    localparam logic [STEP_W-1:0] S_DREM   = 5'd3;
    localparam logic [STEP_W-1:0] S_GRP    = 5'd4;
    localparam logic [STEP_W-1:0] S_HUND   = 5'd5;
    localparam logic [STEP_W-1:0] S_REST   = 5'd6;
    localparam logic [STEP_W-1:0] S_EHUND  = 5'd7;
    localparam logic [STEP_W-1:0] S_EHDR   = 5'd8;
    localparam logic [STEP_W-1:0] S_TENS   = 5'd9;
    localparam logic [STEP_W-1:0] S_RCHK   = 5'd10;
    localparam logic [STEP_W-1:0] S_ETEEN  = 5'd11;
    localparam logic [STEP_W-1:0] S_ETENS  = 5'd12;
    localparam logic [STEP_W-1:0] S_EONES  = 5'd13;
    localparam logic [STEP_W-1:0] S_SCHK   = 5'd14;
    localparam logic [STEP_W-1:0] S_ESCALE = 5'd15;
    localparam logic [STEP_W-1:0] S_NCHK   = 5'd16;
    localparam logic [STEP_W-1:0] S_NEXT   = 5'd17;
    localparam logic [STEP_W-1:0] S_FLUSH  = 5'd18;
    localparam logic [STEP_W-1:0] S_EZERO  = 5'd19;

endpackage

`default_nettype wire

FILE: src/iwt_ucode_rom.sv
// microcode program: one control word per step, with jump condition and target
// depends on iwt_pkg
`timescale 1ns / 1ps
`default_nettype none

module iwt_ucode_rom (
    input  logic [iwt_pkg::STEP_W-1:0] i_step,
    output iwt_pkg::t_uop              o_uop
);
    import iwt_pkg::*;

    always_comb begin
        case (i_step)
            S_IDLE:   o_uop = '{OP_WAIT,    W_ZERO,    C_NEVER,     S_IDLE};
            S_ZCHK:   o_uop = '{OP_NOP,     W_ZERO,    C_VAL_ZERO,  S_EZERO};
            S_DMUL:   o_uop = '{OP_DIV_MUL, W_ZERO,    C_NEVER,     S_IDLE};
            S_DREM:   o_uop = '{OP_DIV_REM, W_ZERO,    C_GI_NOT2,   S_DMUL};
            S_GRP:    o_uop = '{OP_NOP,     W_ZERO,    C_GRP_ZERO,  S_NCHK};
            S_HUND:   o_uop = '{OP_LD_HUND, W_ZERO,    C_NEVER,     S_IDLE};
            S_REST:   o_uop = '{OP_LD_REST, W_ZERO,    C_HUND_ZERO, S_TENS};
            S_EHUND:  o_uop = '{OP_EMIT,    W_HUND,    C_NEVER,     S_IDLE};
            S_EHDR:   o_uop = '{OP_EMIT,    W_HUNDRED, C_NEVER,     S_IDLE};
            S_TENS:   o_uop = '{OP_LD_TENS, W_ZERO,    C_REST_ZERO, S_SCHK};
            S_RCHK:   o_uop = '{OP_NOP,     W_ZERO,    C_REST_GE20, S_ETENS};
            S_ETEEN:  o_uop = '{OP_EMIT,    W_REST,    C_ALWAYS,    S_SCHK};
            S_ETENS:  o_uop = '{OP_EMIT,    W_TENS,    C_ONES_ZERO, S_SCHK};
            S_EONES:  o_uop = '{OP_EMIT,    W_ONES,    C_NEVER,     S_IDLE};
            S_SCHK:   o_uop = '{OP_NOP,     W_ZERO,    C_GI_ZERO,   S_FLUSH};
            S_ESCALE: o_uop = '{OP_EMIT,    W_SCALE,   C_NEVER,     S_IDLE};
            S_NCHK:   o_uop = '{OP_NOP,     W_ZERO,    C_GI_ZERO,   S_FLUSH};
            S_NEXT:   o_uop = '{OP_DEC_GI,  W_ZERO,    C_ALWAYS,    S_GRP};
            S_FLUSH:  o_uop = '{OP_FLUSH,   W_ZERO,    C_ALWAYS,    S_IDLE};
            S_EZERO:  o_uop = '{OP_EMIT,    W_ZERO,    C_ALWAYS,    S_FLUSH};
            default:  o_uop = '{OP_NOP,     W_ZERO,    C_ALWAYS,    S_IDLE};
        endcase
    end

endmodule

`default_nettype wire

FILE: src/iwt_datapath.sv
// datapath: base-1000 group split by reciprocal multiply, digit extraction,
// word code selection and status flags for the sequencer
// depends on iwt_pkg
`timescale 1ns / 1ps
`default_nettype none

module iwt_datapath (
    input  logic            i_clk,
    input  logic            i_load,
    input  logic [30:0]     i_value,
    input  logic            i_adv,
    input  iwt_pkg::t_op    i_op,
    input  iwt_pkg::t_wsel  i_wsel,
    output logic [4:0]      o_word,
    output iwt_pkg::t_status o_status
);
    import iwt_pkg::*;

    logic [30:0] r_val;
    logic [62:0] r_prod;
    logic [9:0]  r_grp [4];
    logic [1:0]  r_gi;
    logic [3:0]  r_hund;
    logic [6:0]  r_rest;
    logic [3:0]  r_tens;

    logic [9:0]  grp;
    logic [21:0] quo;
    logic [31:0] quo_x1000;
    logic [9:0]  rem;
    logic [15:0] hund_p;
    logic [9:0]  hund_x100;
    logic [6:0]  rest_n;
    logic [14:0] tens_p;
    logic [6:0]  tens_x10;
    logic [3:0]  ones;

    always_comb begin
        grp       = r_grp[r_gi];
        quo       = r_prod[62:DIV_SHIFT];
        quo_x1000 = 32'(quo) * 32'(GRP_BASE);
        rem       = r_val[9:0] - quo_x1000[9:0];
        hund_p    = 16'(grp) * HUND_RECIP;
        hund_x100 = 10'(r_hund) * HUND_BASE;
        rest_n    = 7'(grp - hund_x100);
        tens_p    = 15'(r_rest) * TENS_RECIP;
        tens_x10  = 7'(r_tens) * TENS_BASE;
        ones      = 4'(r_rest - tens_x10);
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_val <= i_value;
            r_gi  <= '0;
        end else if (i_adv) begin
            case (i_op)
                OP_DIV_MUL: r_prod <= 63'(r_val) * 63'(DIV_RECIP);
                OP_DIV_REM: begin
                    r_grp[r_gi]        <= rem;
                    r_grp[r_gi + 2'd1] <= quo[9:0];
                    r_val              <= 31'(quo);
                    r_gi               <= r_gi + 2'd1;
                end
                OP_LD_HUND: r_hund <= 4'(hund_p >> HUND_SHIFT);
                OP_LD_REST: r_rest <= rest_n;
                OP_LD_TENS: r_tens <= 4'(tens_p >> TENS_SHIFT);
                OP_DEC_GI:  r_gi   <= r_gi - 2'd1;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (i_wsel)
            W_ZERO:    o_word = W_CODE_ZERO;
            W_HUND:    o_word = 5'(r_hund);
            W_HUNDRED: o_word = W_CODE_HUNDRED;
            W_REST:    o_word = 5'(r_rest);
            W_TENS:    o_word = W_CODE_TENS_BASE + 5'(r_tens);
            W_ONES:    o_word = 5'(ones);
            W_SCALE:   o_word = W_CODE_SCALE_BASE + 5'(r_gi);
            default:   o_word = W_CODE_ZERO;
        endcase
    end

    always_comb begin
        o_status.val_zero  = (r_val == '0);
        o_status.gi_two    = (r_gi == 2'd2);
        o_status.gi_zero   = (r_gi == 2'd0);
        o_status.grp_zero  = (grp == '0);
        o_status.hund_zero = (r_hund == '0);
        o_status.rest_zero = (r_rest == '0);
        o_status.rest_ge20 = (r_rest >= TEEN_LIMIT);
        o_status.ones_zero = (ones == '0);
    end

endmodule

`default_nettype wire

FILE: src/integer_to_word_tokens_core.sv
// top level: microcode step counter, jump logic, one-word lookahead and output register
// depends on iwt_pkg, iwt_ucode_rom, iwt_datapath
`timescale 1ns / 1ps
`default_nettype none

// Spells a 31-bit value as English word codes, most significant word first, one word
// per output transfer, with o_last on the final word. A microcode sequencer runs one
// step per cycle while the output side does not stall an emit or flush: three
// multiply/remainder passes split the value into base-1000 groups, then each group
// takes up to thirteen steps to emit its words. A value is taken only while the
// sequencer sits in its idle step, so the next value is accepted only after the flush
// of the previous run, later still while the output side stalls. Each word waits in
// the pending register until the next word or the flush, so the last can be marked.
module integer_to_word_tokens_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [30:0] i_value,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [4:0]  o_word,
    output logic        o_last
);
    import iwt_pkg::*;

    logic [STEP_W-1:0] r_step;
    logic [STEP_W-1:0] n_step;
    logic              r_pend_v;
    logic [4:0]        r_pend;
    logic              r_out_v;
    logic [4:0]        r_out_word;
    logic              r_out_last;

    t_uop    uop;
    t_status status;
    logic [4:0] dp_word;
    logic cond_true;
    logic is_emit;
    logic is_flush;
    logic out_free;
    logic adv;
    logic push;
    logic load;

    iwt_ucode_rom u_rom (
        .i_step (r_step),
        .o_uop  (uop)
    );

    iwt_datapath u_dp (
        .i_clk    (i_clk),
        .i_load   (load),
        .i_value  (i_value),
        .i_adv    (adv),
        .i_op     (uop.op),
        .i_wsel   (uop.wsel),
        .o_word   (dp_word),
        .o_status (status)
    );

    always_comb begin
        case (uop.cond)
            C_NEVER:     cond_true = 1'b0;
            C_ALWAYS:    cond_true = 1'b1;
            C_VAL_ZERO:  cond_true = status.val_zero;
            C_GI_NOT2:   cond_true = !status.gi_two;
            C_GRP_ZERO:  cond_true = status.grp_zero;
            C_HUND_ZERO: cond_true = status.hund_zero;
            C_REST_ZERO: cond_true = status.rest_zero;
            C_REST_GE20: cond_true = status.rest_ge20;
            C_ONES_ZERO: cond_true = status.ones_zero;
            C_GI_ZERO:   cond_true = status.gi_zero;
            default:     cond_true = 1'b0;
        endcase
    end

    always_comb begin
        is_emit  = (uop.op == OP_EMIT);
        is_flush = (uop.op == OP_FLUSH);
        out_free = !r_out_v || i_ready;
        o_ready  = (uop.op == OP_WAIT);
        load     = i_valid && o_ready;
        if (uop.op == OP_WAIT) begin
            adv = i_valid;
        end else begin
            adv = !((is_emit || is_flush) && r_pend_v && !out_free);
        end
        push = adv && r_pend_v && (is_emit || is_flush);
    end

    always_comb begin
        if (!adv) begin
            n_step = r_step;
        end else if (cond_true) begin
            n_step = uop.target;
        end else begin
            n_step = r_step + STEP_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step   <= S_IDLE;
            r_pend_v <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            r_step <= n_step;
            if (adv && is_emit) begin
                r_pend_v <= 1'b1;
            end else if (adv && is_flush) begin
                r_pend_v <= 1'b0;
            end
            if (push) begin
                r_out_v <= 1'b1;
            end else if (i_ready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && is_emit) begin
            r_pend <= dp_word;
        end
        if (push) begin
            r_out_word <= r_pend;
            r_out_last <= is_flush;
        end
    end

    assign o_valid = r_out_v;
    assign o_word  = r_out_word;
    assign o_last  = r_out_last;

`ifndef SYNTHESIS
    a_idle_no_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready |-> !r_pend_v)
        else $error("pending word left over at idle");

    a_step_in_program: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_step <= S_EZERO)
        else $error("step counter outside program");

    a_flush_marks_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && is_flush) |=> (r_out_v && r_out_last && r_step == S_IDLE))
        else $error("flush did not send a last word");

    a_emit_fills_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && is_emit) |=> r_pend_v)
        else $error("emitted word not held");
`endif

endmodule

`default_nettype wire

FILE: tb/integer_to_word_tokens_checker.sv
// checker for integer_to_word_tokens_core: predicts the word run of each value transfer
// and compares every output transfer against it, depends on iwt_pkg
`timescale 1ns / 1ps

module integer_to_word_tokens_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [30:0] i_value,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [4:0]  i_word,
    input  logic        i_last,
    output int          o_fail_count,
    output int          o_pending
);
    import iwt_pkg::*;

    typedef struct packed {
        logic [4:0] word;
        logic       last;
    } t_word_tok;

    t_word_tok word_q[$];
    int        fail_count = 0;

    assign o_fail_count = fail_count;

    task automatic push_word(input logic [4:0] code);
        t_word_tok tok;
        tok.word = code;
        tok.last = 1'b0;
        word_q.push_back(tok);
    endtask

    task automatic spell_group(input int unsigned grp);
        int unsigned hund;
        int unsigned rest;
        hund = grp / 100;
        rest = grp % 100;
        if (hund != 0) begin
            push_word(5'(hund));
            push_word(W_CODE_HUNDRED);
        end
        if (rest != 0) begin
            if (rest < 20) begin
                push_word(5'(rest));
            end else begin
                push_word(5'(W_CODE_TENS_BASE + rest / 10));
                if (rest % 10 != 0) begin
                    push_word(5'(rest % 10));
                end
            end
        end
    endtask

    task automatic spell_value(input logic [30:0] v);
        int unsigned groups [4];
        int unsigned val;
        t_word_tok   tok;
        val = 32'(v);
        if (val == 0) begin
            push_word(W_CODE_ZERO);
        end else begin
            groups[0] = val % 1000;
            groups[1] = (val / 1000) % 1000;
            groups[2] = (val / 1000000) % 1000;
            groups[3] = val / 1000000000;
            for (int g = 3; g >= 0; g--) begin
                if (groups[g] != 0) begin
                    spell_group(groups[g]);
                    if (g > 0) begin
                        push_word(5'(W_CODE_SCALE_BASE + g));
                    end
                end
            end
        end
        // flag the final word of this run
        tok = word_q.pop_back();
        tok.last = 1'b1;
        word_q.push_back(tok);
    endtask

    always @(posedge i_clk) begin
        t_word_tok want;
        if (i_rst_n) begin
            if (i_out_valid && i_out_ready) begin
                if (word_q.size() == 0) begin
                    $error("word transfer with nothing expected: word %0d last %0d",
                           i_word, i_last);
                    fail_count++;
                end else begin
                    want = word_q.pop_front();
                    if (i_word !== want.word) begin
                        $error("word mismatch: expected %0d actual %0d", want.word, i_word);
                        fail_count++;
                    end
                    if (i_last !== want.last) begin
                        $error("last mismatch: expected %0d actual %0d", want.last, i_last);
                        fail_count++;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                spell_value(i_value);
            end
        end
        o_pending <= word_q.size();
    end

endmodule

FILE: tb/tb_top.sv
// testbench top for integer_to_word_tokens_core: drives value transfers and the output
// ready, depends on integer_to_word_tokens_core and integer_to_word_tokens_checker
`timescale 1ns / 1ps

module tb_top;

    localparam logic [30:0] VALUE_MAX = 31'h7FFF_FFFF;

    logic        i_clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [30:0] in_value;
    logic        out_valid;
    logic        out_ready;
    logic [4:0]  out_word;
    logic        out_last;
    int          fail_count;
    int          pending;

    bit idle_en  = 1'b0;
    bit hold_req = 1'b0;

    logic [30:0] directed_values [] = '{
        31'd0, 31'd1, 31'd9, 31'd10, 31'd11, 31'd15, 31'd19, 31'd20, 31'd21, 31'd99,
        31'd100, 31'd101, 31'd110, 31'd999, 31'd1000, 31'd1001, 31'd12345, 31'd100000,
        31'd1000000, 31'd1000001, 31'd1000010000, 31'd1000000000, 31'd1234567891,
        31'd2000000000, VALUE_MAX
    };

    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    integer_to_word_tokens_core u_top (
        .i_clk   (i_clk),
        .i_rst_n (rst_n),
        .i_valid (in_valid),
        .o_ready (in_ready),
        .i_value (in_value),
        .o_valid (out_valid),
        .i_ready (out_ready),
        .o_word  (out_word),
        .o_last  (out_last)
    );

    integer_to_word_tokens_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_value      (in_value),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_word       (out_word),
        .i_last       (out_last),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    function automatic int unsigned pick_group();
        case ($urandom_range(0, 5))
            0, 1:    return 0;
            2:       return $urandom_range(1, 19);
            3:       return $urandom_range(1, 9) * 100 + $urandom_range(0, 9) * 10;
            default: return $urandom_range(1, 999);
        endcase
    endfunction

    function automatic logic [30:0] rand_value();
        longint unsigned v;
        case ($urandom_range(0, 3))
            0: v = $urandom() & 32'h7FFF_FFFF;
            1: v = $urandom_range(0, 999);
            default: begin
                v = longint'($urandom_range(0, 2)) * 1000000000 +
                    longint'(pick_group()) * 1000000 +
                    longint'(pick_group()) * 1000 + longint'(pick_group());
                if (v > VALUE_MAX) begin
                    v = v - 1000000000;
                end
            end
        endcase
        return v[30:0];
    endfunction

    task automatic send_value(input logic [30:0] v);
        if (idle_en && $urandom_range(0, 3) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_value <= v;
        do @(posedge i_clk); while (!in_ready);
    endtask

    // output side: random stall bursts plus one long hold-off on request
    initial begin
        out_ready <= 1'b0;
        @(posedge i_clk);
        while (!rst_n) @(posedge i_clk);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                out_ready <= 1'b0;
                repeat (500) @(posedge i_clk);
            end else if (idle_en && $urandom_range(0, 5) == 0) begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge i_clk);
            end else begin
                out_ready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    initial begin
        rst_n    <= 1'b0;
        in_valid <= 1'b0;
        in_value <= '0;
        repeat (10) @(posedge i_clk);
        rst_n   <= 1'b1;
        idle_en = 1'b1;
        foreach (directed_values[k]) begin
            send_value(directed_values[k]);
        end
        for (int n = 0; n < 400; n++) begin
            if (n == 120) begin
                hold_req = 1'b1;
            end
            if (n == 240) begin
                // wait for the whole backlog to drain
                in_valid <= 1'b0;
                do @(posedge i_clk); while (pending != 0);
            end
            if (n == 350) begin
                idle_en = 1'b0;
            end
            send_value(rand_value());
        end
        in_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (60) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

FILE: integer_to_word_tokens_core.f
src/iwt_pkg.sv
src/iwt_ucode_rom.sv
src/iwt_datapath.sv
src/integer_to_word_tokens_core.sv
tb/integer_to_word_tokens_checker.sv
tb/tb_top.sv
